[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file mped_checker
// Implication forms with a clock and an active-low disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds too.
`define MPED_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define MPED_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[sv/mped_pkg.sv]
// ----------------------------------------------------------------------------
// mped_pkg
// Types and fixed constants of the priority event dispatcher.
// ----------------------------------------------------------------------------
package mped_pkg;

    localparam int OPCODE_W   = 1;
    localparam int HANDLE_W   = 16;
    localparam int PRIO_W     = 2;
    localparam int CORE_W     = 5;
    localparam int RUN_W      = 5;

    localparam logic [RUN_W-1:0] RUN_MAX = 5'd31;

    localparam logic [OPCODE_W-1:0] OP_POST  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_FETCH = 1'b1;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [1:0] {
        KIND_POST,
        KIND_POST_BAD,
        KIND_FETCH
    } mped_kind_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_EXEC,
        BACK_DONE
    } mped_state_t;

    typedef struct packed {
        mped_kind_t          kind;
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   prio;
        logic                retire;
        logic [PRIO_W-1:0]   retire_prio;
    } mped_item_t;

endpackage

[sv/mped_front.sv]
// ----------------------------------------------------------------------------
// mped_front
// Accepts input beats, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module mped_front import mped_pkg::*; #(
    parameter int PRIORITY_LEVELS = 4,
    parameter int HANDLE_WIDTH    = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OPCODE_W-1:0] s_opcode,
    input  logic [HANDLE_W-1:0] s_event_handle,
    input  logic [PRIO_W-1:0]   s_event_priority,
    input  logic                s_has_previous,
    input  logic [PRIO_W-1:0]   s_previous_priority,
    output logic                q_valid,
    input  logic                q_ready,
    output mped_item_t          q_item
);

    localparam logic [HANDLE_W-1:0] HANDLE_MASK = (HANDLE_WIDTH >= HANDLE_W) ?
        {HANDLE_W{1'b1}} : HANDLE_W'((33'd1 << HANDLE_WIDTH) - 33'd1);

    mped_item_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    mped_item_t             item_in;
    logic                   push, pop;

    // Classify: range-check priorities, mask the handle
    always_comb begin
        item_in.handle      = s_event_handle & HANDLE_MASK;
        item_in.prio        = s_event_priority;
        item_in.retire      = s_has_previous && (32'(s_previous_priority) < PRIORITY_LEVELS);
        item_in.retire_prio = s_previous_priority;
        if (s_opcode == OP_FETCH) begin
            item_in.kind = KIND_FETCH;
        end else if (32'(s_event_priority) < PRIORITY_LEVELS) begin
            item_in.kind = KIND_POST;
        end else begin
            item_in.kind = KIND_POST_BAD;
        end
    end

    assign s_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

[sv/mped_back.sv]
// ----------------------------------------------------------------------------
// mped_back
// Executes queued posts and fetches against the per-priority FIFOs and
// running counts, and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module mped_back import mped_pkg::*; #(
    parameter int PRIORITY_LEVELS = 4,
    parameter int FIFO_DEPTH      = 16,
    parameter int HANDLE_WIDTH    = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CORE_W-1:0]   core_count,
    input  logic                q_valid,
    output logic                q_ready,
    input  mped_item_t          q_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_start_worker,
    output logic                m_queue_full,
    output logic                m_dispatched,
    output logic [HANDLE_W-1:0] m_out_handle,
    output logic [PRIO_W-1:0]   m_out_priority
);

    localparam int LW    = $clog2(PRIORITY_LEVELS);
    localparam int DW    = $clog2(FIFO_DEPTH);
    localparam int FW    = $clog2(FIFO_DEPTH + 1);
    localparam int SW    = DW + 1;
    localparam int AW    = LW + DW;
    localparam int HW    = (HANDLE_WIDTH < HANDLE_W) ? HANDLE_WIDTH : HANDLE_W;
    localparam int SUMW  = RUN_W + LW;

    mped_state_t state_reg, state_next;
    mped_item_t  cur_reg;

    logic [DW-1:0]    head_reg [PRIORITY_LEVELS];
    logic [DW-1:0]    head_next [PRIORITY_LEVELS];
    logic [FW-1:0]    fill_reg [PRIORITY_LEVELS];
    logic [FW-1:0]    fill_next [PRIORITY_LEVELS];
    logic [RUN_W-1:0] run_reg [PRIORITY_LEVELS];
    logic [RUN_W-1:0] run_next [PRIORITY_LEVELS];

    logic [HW-1:0]    mem [2**AW];
    logic [HW-1:0]    rdata_reg;

    logic             full_reg, found_reg;
    logic [LW-1:0]    pick_reg;
    logic [SUMW-1:0]  total_reg, upper_reg;

    logic             m_valid_reg;
    logic             start_reg, qfull_reg, disp_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [PRIO_W-1:0]   prio_reg;
    logic             start_next, qfull_next, disp_next;
    logic [HANDLE_W-1:0] handle_next;
    logic [PRIO_W-1:0]   prio_next;

    logic             out_free, pop, exec, load_out;
    logic             is_post, is_fetch;
    logic [LW-1:0]    cur_lv, ret_lv, pick, sel_lv;
    logic             found, full;
    logic [DW-1:0]    head_sel, head_inc, slot;
    logic [FW-1:0]    fill_sel;
    logic [SW-1:0]    slot_sum;
    logic [AW-1:0]    addr;
    logic [SUMW-1:0]  total, upper;
    logic             start_now;

    assign is_post  = (cur_reg.kind == KIND_POST);
    assign is_fetch = (cur_reg.kind == KIND_FETCH);
    assign cur_lv   = LW'(cur_reg.prio);
    assign ret_lv   = LW'(cur_reg.retire_prio);

    // Highest non-empty level
    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
            if (fill_reg[lv] != '0) begin
                found = 1'b1;
                pick  = LW'(lv);
            end
        end
    end

    assign sel_lv   = is_fetch ? pick : cur_lv;
    assign head_sel = head_reg[sel_lv];
    assign fill_sel = fill_reg[sel_lv];
    assign full     = (fill_sel == FW'(FIFO_DEPTH));
    assign head_inc = (head_sel == DW'(FIFO_DEPTH - 1)) ? '0 : head_sel + DW'(1);

    // Tail slot, wrapped once around the ring
    always_comb begin
        slot_sum = SW'(head_sel) + SW'(fill_sel);
        if (slot_sum >= SW'(FIFO_DEPTH)) begin
            slot_sum = slot_sum - SW'(FIFO_DEPTH);
        end
        slot = slot_sum[DW-1:0];
    end

    assign addr = {sel_lv, (is_fetch ? head_sel : slot)};

    // Running totals: all levels, and levels strictly above the posted one
    always_comb begin
        total = '0;
        upper = '0;
        for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
            total = total + SUMW'(run_reg[lv]);
            if (LW'(lv) > cur_lv) begin
                upper = upper + SUMW'(run_reg[lv]);
            end
        end
    end

    // Control
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE: begin
                if (q_valid) begin
                    state_next = BACK_EXEC;
                end
            end
            BACK_EXEC: begin
                state_next = BACK_DONE;
            end
            BACK_DONE: begin
                if (out_free) begin
                    state_next = q_valid ? BACK_EXEC : BACK_IDLE;
                end
            end
            default: begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        exec     = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            BACK_IDLE: begin
                pop = q_valid;
            end
            BACK_EXEC: begin
                exec = 1'b1;
            end
            BACK_DONE: begin
                load_out = out_free;
                pop      = q_valid && out_free;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    assign q_ready = pop;

    // State updates of the FIFOs and running counts
    always_comb begin
        for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
            head_next[lv] = head_reg[lv];
            fill_next[lv] = fill_reg[lv];
            run_next[lv]  = run_reg[lv];
            if (exec && LW'(lv) == sel_lv) begin
                if (is_post && !full) begin
                    fill_next[lv] = fill_reg[lv] + FW'(1);
                end else if (is_fetch && found) begin
                    head_next[lv] = head_inc;
                    fill_next[lv] = fill_reg[lv] - FW'(1);
                end
            end
            if (exec && is_fetch) begin
                // retire first, then count the dispatched event
                if (cur_reg.retire && LW'(lv) == ret_lv && run_next[lv] != '0) begin
                    run_next[lv] = run_next[lv] - RUN_W'(1);
                end
                if (found && LW'(lv) == pick && run_next[lv] != RUN_MAX) begin
                    run_next[lv] = run_next[lv] + RUN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BACK_IDLE;
            m_valid_reg <= 1'b0;
            for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
                head_reg[lv] <= '0;
                fill_reg[lv] <= '0;
                run_reg[lv]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
                head_reg[lv] <= head_next[lv];
                fill_reg[lv] <= fill_next[lv];
                run_reg[lv]  <= run_next[lv];
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Handle store: one write or one registered read per item
    always_ff @(posedge aclk) begin
        if (exec && is_post && !full) begin
            mem[addr] <= cur_reg.handle[HW-1:0];
        end
        if (exec && is_fetch && found) begin
            rdata_reg <= mem[addr];
        end
    end

    // Item payload and per-item scratch
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= q_item;
        end
        if (exec) begin
            full_reg  <= full;
            found_reg <= found;
            pick_reg  <= pick;
            total_reg <= total;
            upper_reg <= upper;
        end
    end

    assign start_now = (total_reg < SUMW'(core_count)) || (upper_reg > SUMW'(core_count));

    always_comb begin
        start_next  = 1'b0;
        qfull_next  = 1'b0;
        disp_next   = 1'b0;
        handle_next = '0;
        prio_next   = '0;
        case (cur_reg.kind)
            KIND_POST: begin
                start_next = start_now;
                qfull_next = full_reg;
            end
            KIND_POST_BAD: begin
                qfull_next = 1'b1;
            end
            KIND_FETCH: begin
                disp_next = found_reg;
                if (found_reg) begin
                    handle_next = HANDLE_W'(rdata_reg);
                    prio_next   = PRIO_W'(pick_reg);
                end
            end
            default: begin
                qfull_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            start_reg  <= start_next;
            qfull_reg  <= qfull_next;
            disp_reg   <= disp_next;
            handle_reg <= handle_next;
            prio_reg   <= prio_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_start_worker = start_reg;
    assign m_queue_full   = qfull_reg;
    assign m_dispatched   = disp_reg;
    assign m_out_handle   = handle_reg;
    assign m_out_priority = prio_reg;

endmodule

[sv/multicore_priority_event_dispatcher.sv]
// ----------------------------------------------------------------------------
// multicore_priority_event_dispatcher
// Strict-priority event dispatcher: per-priority handle FIFOs, running
// counts per priority and a worker-start decision against the core count.
// ----------------------------------------------------------------------------
// Channel   Ports                       Beat
// s_        s_valid / s_ready           post or fetch request
// m_        m_valid / m_ready           one result per request
// cfg_      cfg_valid / cfg_ready       core_count write (cfg_ready tied high)
//
// An item passes through the back end in an execute state, then a result
// load state; the single-port handle store, read or written once per item,
// sets that pace. An input beat goes through a queue entry and the item
// register before execute; the result register loads with the output free.
// A two-entry queue separates the input side from the back end; a held
// result stalls the back end but not input acceptance until the queue fills.
// Reset is synchronous; FIFOs start empty, no clearing pass is needed.
// ----------------------------------------------------------------------------
module multicore_priority_event_dispatcher import mped_pkg::*; #(
    parameter int PRIORITY_LEVELS = 4,
    parameter int FIFO_DEPTH      = 16,
    parameter int HANDLE_WIDTH    = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CORE_W-1:0]   cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OPCODE_W-1:0] s_opcode,
    input  logic [HANDLE_W-1:0] s_event_handle,
    input  logic [PRIO_W-1:0]   s_event_priority,
    input  logic                s_has_previous,
    input  logic [PRIO_W-1:0]   s_previous_priority,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_start_worker,
    output logic                m_queue_full,
    output logic                m_dispatched,
    output logic [HANDLE_W-1:0] m_out_handle,
    output logic [PRIO_W-1:0]   m_out_priority
);

    logic [CORE_W-1:0] core_count_reg;
    logic              q_valid, q_ready;
    mped_item_t        q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            core_count_reg <= CORE_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            core_count_reg <= cfg_data;
        end
    end

    mped_front #(
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .HANDLE_WIDTH    (HANDLE_WIDTH)
    ) u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (s_opcode),
        .s_event_handle      (s_event_handle),
        .s_event_priority    (s_event_priority),
        .s_has_previous      (s_has_previous),
        .s_previous_priority (s_previous_priority),
        .q_valid             (q_valid),
        .q_ready             (q_ready),
        .q_item              (q_item)
    );

    mped_back #(
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .FIFO_DEPTH      (FIFO_DEPTH),
        .HANDLE_WIDTH    (HANDLE_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .core_count     (core_count_reg),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_start_worker (m_start_worker),
        .m_queue_full   (m_queue_full),
        .m_dispatched   (m_dispatched),
        .m_out_handle   (m_out_handle),
        .m_out_priority (m_out_priority)
    );

endmodule

[sv/mped_checker.sv]
// ----------------------------------------------------------------------------
// mped_checker
// Port-level checks of the dispatcher, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mped_checker import mped_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_start_worker,
    input logic                m_queue_full,
    input logic                m_dispatched,
    input logic [HANDLE_W-1:0] m_out_handle,
    input logic [PRIO_W-1:0]   m_out_priority
);

    logic                        m_stall;
    logic                        fetch_beat;
    logic                        empty_beat;
    logic                        post_flags;
    logic                        out_zero;
    logic [HANDLE_W+PRIO_W+2:0]  m_beat;

    assign m_stall    = m_valid && !m_ready;
    assign fetch_beat = m_valid && m_dispatched;
    assign empty_beat = m_valid && !m_dispatched;
    assign post_flags = m_start_worker || m_queue_full;
    assign out_zero   = (m_out_handle == '0) && (m_out_priority == '0);
    assign m_beat     = {m_start_worker, m_queue_full, m_dispatched, m_out_handle,
                         m_out_priority};

    // Hold a stalled result beat
    `MPED_ASSERT_NEXT(a_result_held, aclk, aresetn, m_stall, m_valid && $stable(m_beat))

    // A fetch result never carries post flags
    `MPED_ASSERT_NOW(a_fetch_no_post_flags, aclk, aresetn, fetch_beat, !post_flags)

    // Nothing dispatched means zero handle and priority
    `MPED_ASSERT_NOW(a_idle_fetch_zero, aclk, aresetn, empty_beat, out_zero)

    // No result right after reset leaves
    `MPED_ASSERT_NOW(a_no_result_after_reset, aclk, aresetn, $past(!aresetn), !m_valid)

endmodule

bind multicore_priority_event_dispatcher mped_checker u_checker (.*);

[tb/mped_dispatch_checker.sv]
// ----------------------------------------------------------------------------
// mped_dispatch_checker
// Watches the configuration, request and result channels of the priority
// event dispatcher. It keeps its own copy of the per-priority handle queues,
// the running counts and the core count, works out the expected result of
// every accepted request, and compares each result beat field by field with
// the oldest expected result.
// ----------------------------------------------------------------------------
module mped_dispatch_checker import mped_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CORE_W-1:0]   cfg_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [OPCODE_W-1:0] s_opcode,
    input  logic [HANDLE_W-1:0] s_event_handle,
    input  logic [PRIO_W-1:0]   s_event_priority,
    input  logic                s_has_previous,
    input  logic [PRIO_W-1:0]   s_previous_priority,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic                m_start_worker,
    input  logic                m_queue_full,
    input  logic                m_dispatched,
    input  logic [HANDLE_W-1:0] m_out_handle,
    input  logic [PRIO_W-1:0]   m_out_priority,
    output int                  fail_count,
    output int                  pending
);

    localparam int LEVELS      = 4;
    localparam int DEPTH       = 16;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic                start_worker;
        logic                queue_full;
        logic                dispatched;
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   prio;
    } outcome_t;

    logic [HANDLE_W-1:0] handle_mem [LEVELS*DEPTH];
    int unsigned         rd_ptr     [LEVELS];
    int unsigned         fill       [LEVELS];
    logic [RUN_W-1:0]    running    [LEVELS];
    logic [CORE_W-1:0]   cores;
    outcome_t            expected_q [$];
    outcome_t            got;
    outcome_t            want;
    outcome_t            predicted;
    int                  mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what, input int unsigned seen,
                                   input int unsigned wanted);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s: got 0x%0h, expected 0x%0h", $time, what, seen,
                     wanted);
        mismatches++;
    endtask

    // Apply one request to the local queues and counts; return its result beat.
    function automatic outcome_t schedule_request(
        input logic [OPCODE_W-1:0] op,
        input logic [HANDLE_W-1:0] handle,
        input logic [PRIO_W-1:0]   prio,
        input logic                retire,
        input logic [PRIO_W-1:0]   retire_prio
    );
        outcome_t    res;
        int unsigned total;
        int unsigned acc;
        int          overflow_lv;
        int          lv;
        bit          found;

        res = '0;
        if (op == OP_POST) begin
            if (fill[prio] >= DEPTH) begin
                res.queue_full = 1'b1;
            end else begin
                handle_mem[int'(prio)*DEPTH + (rd_ptr[prio] + fill[prio]) % DEPTH] = handle;
                fill[prio] = fill[prio] + 1;
            end
            // walk from the top level down; first level whose sum passes the cores
            total       = 0;
            acc         = 0;
            overflow_lv = -1;
            for (lv = LEVELS - 1; lv >= 0; lv--) begin
                total = total + running[lv];
                if (overflow_lv < 0 && acc + running[lv] > cores)
                    overflow_lv = lv;
                acc = acc + running[lv];
            end
            res.start_worker = (total < cores) || (int'(prio) < overflow_lv);
        end else begin
            if (retire && running[retire_prio] != '0)
                running[retire_prio] = running[retire_prio] - 1'b1;
            found = 1'b0;
            for (lv = LEVELS - 1; lv >= 0; lv--) begin
                if (!found && fill[lv] != 0) begin
                    found          = 1'b1;
                    res.dispatched = 1'b1;
                    res.handle     = handle_mem[lv*DEPTH + rd_ptr[lv]];
                    res.prio       = lv[PRIO_W-1:0];
                    rd_ptr[lv]     = (rd_ptr[lv] + 1) % DEPTH;
                    fill[lv]       = fill[lv] - 1;
                    // saturate the running count
                    if (running[lv] != RUN_MAX)
                        running[lv] = running[lv] + 1'b1;
                end
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                rd_ptr[i]  = 0;
                fill[i]    = 0;
                running[i] = '0;
            end
            cores = 5'd1;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                cores = cfg_data;
            if (m_valid && m_ready) begin
                got.start_worker = m_start_worker;
                got.queue_full   = m_queue_full;
                got.dispatched   = m_dispatched;
                got.handle       = m_out_handle;
                got.prio         = m_out_priority;
                if (expected_q.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding",
                                    32'(got.handle), 0);
                end else begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    if (got.start_worker != want.start_worker)
                        report_mismatch("start_worker", 32'(got.start_worker),
                                        32'(want.start_worker));
                    if (got.queue_full != want.queue_full)
                        report_mismatch("queue_full", 32'(got.queue_full),
                                        32'(want.queue_full));
                    if (got.dispatched != want.dispatched)
                        report_mismatch("dispatched", 32'(got.dispatched),
                                        32'(want.dispatched));
                    if (got.handle != want.handle)
                        report_mismatch("out_handle", 32'(got.handle), 32'(want.handle));
                    if (got.prio != want.prio)
                        report_mismatch("out_priority", 32'(got.prio), 32'(want.prio));
                end
            end
            if (s_valid && s_ready) begin
                predicted  = schedule_request(s_opcode, s_event_handle, s_event_priority,
                                              s_has_previous, s_previous_priority);
                expected_q = {expected_q, predicted};
            end
        end
        pending <= expected_q.size();
    end

endmodule

[tb/tb_multicore_priority_event_dispatcher.sv]
// ----------------------------------------------------------------------------
// tb_multicore_priority_event_dispatcher
// Drives post and fetch requests into the dispatcher under random idling on
// both channels, with a directed opening, worker-style traffic that retires
// what it was handed, floods that drive running counts to saturation, and
// plain noise, across core counts from 0 to 31. A separate checker predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module tb_multicore_priority_event_dispatcher;
    import mped_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int IDLE_PCT        = 28;
    localparam int HOLD_CYCLES     = 64;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 10;
    localparam logic [PRIO_W-1:0] PRIO_TOP = 2'd3;

    typedef enum logic [1:0] {
        MIX_WORKER,
        MIX_FLOOD,
        MIX_NOISE
    } traffic_t;

    logic                aclk                = 1'b0;
    logic                aresetn             = 1'b0;
    logic                cfg_valid           = 1'b0;
    logic                cfg_ready;
    logic [CORE_W-1:0]   cfg_data            = '0;
    logic                s_valid             = 1'b0;
    logic                s_ready;
    logic [OPCODE_W-1:0] s_opcode            = OP_POST;
    logic [HANDLE_W-1:0] s_event_handle      = '0;
    logic [PRIO_W-1:0]   s_event_priority    = '0;
    logic                s_has_previous      = 1'b0;
    logic [PRIO_W-1:0]   s_previous_priority = '0;
    logic                m_valid;
    logic                m_ready             = 1'b0;
    logic                m_start_worker;
    logic                m_queue_full;
    logic                m_dispatched;
    logic [HANDLE_W-1:0] m_out_handle;
    logic [PRIO_W-1:0]   m_out_priority;

    int                  fail_count;
    int                  pending;

    logic                no_idle      = 1'b0;
    logic                hold_trigger = 1'b0;
    bit                  hold_seen    = 1'b0;
    int                  hold_left    = 0;
    int                  quiet        = 0;
    int                  posts        = 0;
    int                  fetches      = 0;
    int                  settings     = 0;
    logic [PRIO_W-1:0]   running_prio [$];

    traffic_t phase_mix [PHASES] = '{MIX_WORKER, MIX_NOISE, MIX_FLOOD, MIX_WORKER,
                                     MIX_WORKER, MIX_FLOOD, MIX_WORKER, MIX_NOISE};

    always #5 aclk = ~aclk;

    multicore_priority_event_dispatcher u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (s_opcode),
        .s_event_handle      (s_event_handle),
        .s_event_priority    (s_event_priority),
        .s_has_previous      (s_has_previous),
        .s_previous_priority (s_previous_priority),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_start_worker      (m_start_worker),
        .m_queue_full        (m_queue_full),
        .m_dispatched        (m_dispatched),
        .m_out_handle        (m_out_handle),
        .m_out_priority      (m_out_priority)
    );

    mped_dispatch_checker u_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (s_opcode),
        .s_event_handle      (s_event_handle),
        .s_event_priority    (s_event_priority),
        .s_has_previous      (s_has_previous),
        .s_previous_priority (s_previous_priority),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_start_worker      (m_start_worker),
        .m_queue_full        (m_queue_full),
        .m_dispatched        (m_dispatched),
        .m_out_handle        (m_out_handle),
        .m_out_priority      (m_out_priority),
        .fail_count          (fail_count),
        .pending             (pending)
    );

    // Result side: random stalls, one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_trigger && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Track handed-out events so workers can retire them later; valid and
    // ready are stable at the falling edge, so the beat is certain.
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready && m_dispatched)
            running_prio = {running_prio, m_out_priority};
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without any beat", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_beat(
        input logic [OPCODE_W-1:0] op,
        input logic [HANDLE_W-1:0] handle,
        input logic [PRIO_W-1:0]   prio,
        input logic                retire,
        input logic [PRIO_W-1:0]   retire_prio
    );
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_opcode            <= op;
        s_event_handle      <= handle;
        s_event_priority    <= prio;
        s_has_previous      <= retire;
        s_previous_priority <= retire_prio;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_POST)
            posts++;
        else
            fetches++;
    endtask

    // Drop valid and hold until every outstanding result beat has come back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    task automatic write_cores(input logic [CORE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic random_request(input traffic_t mix);
        logic [OPCODE_W-1:0] op;
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   prio;
        logic                retire;
        logic [PRIO_W-1:0]   retire_prio;
        int                  pick;

        handle      = HANDLE_W'($urandom);
        prio        = PRIO_W'($urandom);
        retire      = 1'($urandom);
        retire_prio = PRIO_W'($urandom);
        case (mix)
            MIX_WORKER: begin
                op = ($urandom_range(99) < 45) ? OP_POST : OP_FETCH;
                // mostly retire an event this worker really got
                if (op == OP_FETCH && running_prio.size() != 0 &&
                    $urandom_range(9) != 0) begin
                    pick        = $urandom_range(running_prio.size() - 1);
                    retire      = 1'b1;
                    retire_prio = running_prio[pick];
                    running_prio.delete(pick);
                end
            end
            MIX_FLOOD: begin
                op = ($urandom_range(99) < 55) ? OP_FETCH : OP_POST;
                if ($urandom_range(9) < 8)
                    prio = PRIO_TOP;
                if (op == OP_FETCH)
                    retire = 1'b0;
            end
            default: begin
                op = OPCODE_W'($urandom);
            end
        endcase
        send_beat(op, handle, prio, retire, retire_prio);
    endtask

    initial begin
        logic [CORE_W-1:0] cores;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening at the reset core count of one.
        // Fetch on an empty dispatcher while retiring with nothing running.
        send_beat(OP_FETCH, HANDLE_W'($urandom), PRIO_W'($urandom), 1'b1, 2'd0);
        send_beat(OP_POST, 16'hFFFF, 2'd3, 1'b1, 2'd3);
        send_beat(OP_POST, 16'h5A5A, 2'd2, 1'b0, 2'd0);
        send_beat(OP_POST, 16'hA5A5, 2'd1, 1'b1, 2'd1);
        send_beat(OP_POST, 16'h0000, 2'd0, 1'b0, 2'd2);
        send_beat(OP_FETCH, 16'hFFFF, 2'd3, 1'b0, 2'd3);
        send_beat(OP_FETCH, 16'h0000, 2'd0, 1'b0, 2'd0);
        // Two levels running: a low post starts a worker, a top post does not.
        send_beat(OP_POST, 16'h1234, 2'd1, 1'b0, 2'd0);
        send_beat(OP_POST, 16'hFEDC, 2'd3, 1'b1, 2'd2);
        // Fill the lowest queue; the last post overflows it.
        for (int i = 0; i < 16; i++)
            send_beat(OP_POST, HANDLE_W'($urandom), 2'd0, 1'($urandom), PRIO_W'($urandom));

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       cores = 5'd16;
                1:       cores = 5'd0;
                2:       cores = 5'd31;
                3:       cores = 5'd1;
                7:       cores = CORE_W'($urandom_range(31));
                default: cores = CORE_W'($urandom_range(16, 1));
            endcase
            no_idle <= (ph == 6);
            drain();
            write_cores(cores);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 3 && n == 20)
                    hold_trigger <= 1'b1;
                if (ph == 4 && n == 50)
                    drain();
                random_request(phase_mix[ph]);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d posts and %0d fetches over %0d core counts from 0 to 31",
                 posts, fetches, settings);
        $display("with full queues, empty fetches, saturating run counts and a long stall");
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
